// ===== hdl/assert_macros.svh =====
// assertion helpers included by the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue: request and result
// items, the stored entry, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEF_CAPACITY = 16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DQ_WAIT,
    S_ENQ_SCAN,
    S_ENQ_PUT
  } spq_state_e;

  typedef struct packed {
    spq_op_e            func;
    logic signed [31:0] data_value;
    logic signed [31:0] priority_req;
  } spq_req_t;

  typedef struct packed {
    spq_status_e        status;
    logic signed [31:0] head_data;
    logic signed [31:0] head_priority;
    logic               now_empty;
    logic               now_full;
    logic [4:0]         entry_count;
  } spq_result_t;

  typedef struct packed {
    logic signed [31:0] data_value;
    logic signed [31:0] prio;
  } spq_entry_t;

endpackage : spq_pkg
`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a circular entry memory; smallest
// priority at the head, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//   channel   ports                     transfer when
//   request   start, busy, req_i        start high and busy low
//   result    done_o, result_o          done_o high (one cycle, no stall)
//
// Rejected items, enqueue into an empty queue: result in the cycle after start.
// Dequeue: registered read of the head entry, result formed in S_DQ_WAIT.
// Enqueue: n = entries of larger priority, each moves one slot toward the
// tail in S_ENQ_SCAN; at most one memory read and one write per cycle on the scan.
// Reset clears state, count, head, scan position and done; the memory needs no clearing.
// busy is high from a dequeue or scanning enqueue until its result is shown.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  input  wire spq_req_t req_i,
  output logic       done_o,
  output spq_result_t result_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  spq_state_e         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  spq_req_t           req_q, req_d;
  spq_result_t        res_q, res_d;
  logic               done_q, done_d;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  spq_entry_t         wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  spq_entry_t         rd_data;
  spq_entry_t         new_entry;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic               move_on;

  // logical slot to physical address, head_q is slot 0
  function automatic logic [IDX_W-1:0] phys_addr(input logic [CNT_W-1:0] slot);
    logic [IDX_W:0] sum;
    sum = {1'b0, head_q} + (IDX_W+1)'(slot);
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic spq_result_t make_result(input spq_status_e st,
                                              input spq_entry_t ent,
                                              input logic [CNT_W-1:0] cnt);
    spq_result_t r;
    r.status        = st;
    r.head_data     = ent.data_value;
    r.head_priority = ent.prio;
    r.now_empty     = (cnt == '0);
    r.now_full      = (cnt == CNT_W'(CAPACITY));
    r.entry_count   = 5'(cnt);
    return r;
  endfunction

  assign accept    = start && !busy;
  assign is_full   = (count_q == CNT_W'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign new_entry = '{data_value: req_q.data_value, prio: req_q.priority_req};
  // held entry at slot pos-1 moves down when its priority is strictly larger
  assign move_on   = ($signed(rd_data.prio) > $signed(req_q.priority_req));

  spq_mem #(
    .Depth (CAPACITY),
    .AddrW (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.func == OP_DEQ) begin
            if (!is_empty) state_d = S_DQ_WAIT;
          end else if (!is_full && !is_empty) begin
            state_d = S_ENQ_SCAN;
          end
        end
      end
      S_DQ_WAIT: state_d = S_IDLE;
      S_ENQ_SCAN: begin
        if (!move_on) begin
          state_d = S_IDLE;
        end else if (pos_q == CNT_W'(1)) begin
          state_d = S_ENQ_PUT;
        end
      end
      S_ENQ_PUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  // the scan reads slot pos-2 while writing slot pos, so no access overlaps
  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    pos_d   = pos_q;
    req_d   = req_q;
    res_d   = res_q;
    done_d  = 1'b0;
    wr_en   = 1'b0;
    wr_addr = phys_addr(pos_q);
    wr_data = new_entry;
    rd_en   = 1'b0;
    rd_addr = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          if (req_i.func == OP_DEQ) begin
            if (is_empty) begin
              res_d  = make_result(ST_EMPTY, '0, count_q);
              done_d = 1'b1;
            end else begin
              rd_en = 1'b1;
            end
          end else if (is_full) begin
            res_d  = make_result(ST_FULL, '0, count_q);
            done_d = 1'b1;
          end else if (is_empty) begin
            wr_en   = 1'b1;
            wr_addr = head_q;
            wr_data = '{data_value: req_i.data_value, prio: req_i.priority_req};
            count_d = CNT_W'(1);
            res_d   = make_result(ST_DONE, '0, CNT_W'(1));
            done_d  = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys_addr(count_q - CNT_W'(1));
            pos_d   = count_q;
          end
        end
      end
      S_DQ_WAIT: begin
        count_d = count_q - CNT_W'(1);
        head_d  = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);
        res_d   = make_result(ST_DONE, rd_data, count_q - CNT_W'(1));
        done_d  = 1'b1;
      end
      S_ENQ_SCAN: begin
        wr_en = 1'b1;
        if (move_on) begin
          wr_data = rd_data;
          pos_d   = pos_q - CNT_W'(1);
          if (pos_q != CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = phys_addr(pos_q - CNT_W'(2));
          end
        end else begin
          count_d = count_q + CNT_W'(1);
          res_d   = make_result(ST_DONE, '0, count_q + CNT_W'(1));
          done_d  = 1'b1;
        end
      end
      S_ENQ_PUT: begin
        wr_en   = 1'b1;
        count_d = count_q + CNT_W'(1);
        res_d   = make_result(ST_DONE, '0, count_q + CNT_W'(1));
        done_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(CAPACITY), "entry count above capacity")
  `ASSERT_AT(a_done_has_item, clk_i, rst_ni, done_q |-> $past(busy || start), "result without a transfer")
  `ASSERT_AT(a_scan_pos, clk_i, rst_ni, (state_q == S_ENQ_SCAN) |-> (pos_q != '0 && pos_q <= count_q && !is_full), "scan position out of range")
  `ASSERT_AT(a_full_flag, clk_i, rst_ni, (done_q && res_q.status == ST_FULL) |-> (res_q.now_full && $past(is_full)), "full rejection with room left")

endmodule : sorted_priority_queue
`default_nettype wire

// ===== hdl/spq_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_mem
// Entry store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spq_mem import spq_pkg::*; #(
  parameter int unsigned Depth = DEF_CAPACITY,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire spq_entry_t       wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output spq_entry_t            rd_data_o
);

  spq_entry_t mem_q [Depth];
  spq_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : spq_mem
`default_nettype wire
